[rtl/bcu_pkg.sv]
// ----------------------------------------------------------------------------
// Binomial coefficient unit package
// Shared widths and constants for the bit-serial binomial coefficient unit.
// ----------------------------------------------------------------------------
package bcu_pkg;

	// Width of each input field and of the serial multiplier's operand.
	localparam int FIELD_W = 32;

	// Default width that the coefficient must fit in before it saturates.
	localparam int RESULT_WIDTH_DEF = 32;

	// Stream data widths: two input fields, and coefficient plus overflow flag.
	localparam int IN_TDATA_W  = 2 * FIELD_W;
	localparam int OUT_TDATA_W = 40;
	localparam int OUT_PAD_W   = OUT_TDATA_W - FIELD_W - 1;

endpackage

[rtl/binomial_coefficient_unit.sv]
// ----------------------------------------------------------------------------
// Binomial coefficient unit
// Computes C(n,k) as a running product accum*(n-k+i)/i with bit-serial
// multiply and divide, saturating with an overflow flag past RESULT_WIDTH.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Payload (lowest bits first)
//  s_axis   | in        | tdata: choose_count[31:0], set_size[63:32]
//  m_axis   | out       | tdata: coefficient[31:0], overflow[32], zero pad
//
//  One transaction in gives one transaction out. Each product step runs
//  a serial multiply over the 32 operand bits, then a serial divide over
//  the RESULT_WIDTH+32 dividend bits. An item takes min(k, n-k) product
//  steps, or fewer once the product overflows.
//  A new transaction is taken whenever the unit is idle, even while the
//  previous result still waits in the output register. Reset clears the
//  control state only; no clearing pass is needed.
// ----------------------------------------------------------------------------
module binomial_coefficient_unit #(
	parameter int RESULT_WIDTH = bcu_pkg::RESULT_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// choose_count[31:0], set_size[63:32]
	input  logic [bcu_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// coefficient[31:0], overflow[32], zeros[39:33]
	output logic [bcu_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
	import bcu_pkg::*;

	localparam int PW = RESULT_WIDTH + FIELD_W;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_PREP   = 6'b000010,
		ST_LOOP   = 6'b000100,
		ST_MUL    = 6'b001000,
		ST_DIV    = 6'b010000,
		ST_FINISH = 6'b100000
	} state_t;

	state_t                  state_q;
	logic [FIELD_W-1:0]      k_q;
	logic [FIELD_W-1:0]      n_q;
	logic [FIELD_W-1:0]      kk_q;
	logic [FIELD_W-1:0]      base_q;
	logic [FIELD_W-1:0]      i_q;
	logic [RESULT_WIDTH-1:0] accum_q;
	logic [FIELD_W-1:0]      fin_coef_q;
	logic                    fin_ovf_q;
	logic [OUT_TDATA_W-1:0]  m_tdata_q;
	logic                    m_tvalid_q;

	logic                    in_xfer;
	logic                    out_load;
	logic [FIELD_W-1:0]      n_minus_k;
	logic                    loop_end;
	logic                    mul_start;
	logic                    mul_busy;
	logic                    mul_done;
	logic [PW-1:0]           mul_prod;
	logic                    div_start;
	logic                    div_busy;
	logic                    div_done;
	logic [PW-1:0]           div_quot;
	logic                    step_ovf;
	logic [PW-1:0]           accum_wide;
	logic [PW-1:0]           ones_wide;

	// Handshake and step decisions.
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign out_load      = (state_q == ST_FINISH) && (!m_tvalid_q || m_axis_tready);
	assign n_minus_k     = n_q - k_q;
	assign loop_end      = (i_q > kk_q);
	assign mul_start     = (state_q == ST_LOOP) && !loop_end;
	assign div_start     = (state_q == ST_MUL) && mul_done;
	assign step_ovf      = |div_quot[PW-1:RESULT_WIDTH];

	// Result width folded onto the 32-bit coefficient field.
	assign accum_wide = {{FIELD_W{1'b0}}, accum_q};
	assign ones_wide  = {{FIELD_W{1'b0}}, {RESULT_WIDTH{1'b1}}};

	bcu_serial_mul #(
		.A_WIDTH (RESULT_WIDTH)
	) u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       (accum_q),
		.b       (base_q + i_q),
		.busy    (mul_busy),
		.done    (mul_done),
		.product (mul_prod)
	);

	bcu_serial_div #(
		.DIVIDEND_WIDTH (PW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mul_prod),
		.divisor  (i_q),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quot)
	);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) state_q <= ST_PREP;
				end
				ST_PREP: begin
					state_q <= (k_q > n_q) ? ST_FINISH : ST_LOOP;
				end
				ST_LOOP: begin
					state_q <= loop_end ? ST_FINISH : ST_MUL;
				end
				ST_MUL: begin
					if (mul_done) state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) state_q <= step_ovf ? ST_FINISH : ST_LOOP;
				end
				ST_FINISH: begin
					if (out_load) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Operand and accumulator registers.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			k_q <= s_axis_tdata[FIELD_W-1:0];
			n_q <= s_axis_tdata[2*FIELD_W-1:FIELD_W];
		end
		case (state_q)
			ST_PREP: begin
				// Use the smaller of k and n-k as the step count.
				if (k_q > (n_q >> 1)) begin
					kk_q   <= n_minus_k;
					base_q <= k_q;
				end else begin
					kk_q   <= k_q;
					base_q <= n_minus_k;
				end
				accum_q    <= RESULT_WIDTH'(1);
				i_q        <= FIELD_W'(1);
				fin_coef_q <= '0;
				fin_ovf_q  <= 1'b0;
			end
			ST_LOOP: begin
				if (loop_end) begin
					fin_coef_q <= accum_wide[FIELD_W-1:0];
					fin_ovf_q  <= 1'b0;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					if (step_ovf) begin
						fin_coef_q <= ones_wide[FIELD_W-1:0];
						fin_ovf_q  <= 1'b1;
					end else begin
						accum_q <= div_quot[RESULT_WIDTH-1:0];
						i_q     <= i_q + 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Output register: holds a finished transaction until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= {{OUT_PAD_W{1'b0}}, fin_ovf_q, fin_coef_q};
		end
	end

	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = m_tdata_q;

	// Checks on the sequencing and the saturated result.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[FIELD_W])
			|-> (m_axis_tdata[FIELD_W-1:0] == ones_wide[FIELD_W-1:0]))
		else $error("overflow result is not saturated");

	assert property (@(posedge clk) disable iff (!arst_n)
		!(mul_busy && div_busy))
		else $error("multiplier and divider busy together");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> m_axis_tvalid)
		else $error("finished result not presented");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOOP) |-> (i_q != '0))
		else $error("zero divisor reached the product loop");

endmodule

[rtl/bcu_serial_mul.sv]
// ----------------------------------------------------------------------------
// Bit-serial multiplier
// Shift-and-add multiplier that consumes one bit of the 32-bit operand per
// cycle, least significant bit first.
// ----------------------------------------------------------------------------
module bcu_serial_mul #(
	parameter int A_WIDTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [A_WIDTH-1:0]                  a,
	input  logic [bcu_pkg::FIELD_W-1:0]         b,
	output logic                                busy,
	output logic                                done,
	output logic [A_WIDTH+bcu_pkg::FIELD_W-1:0] product
);
	import bcu_pkg::*;

	localparam int PW    = A_WIDTH + FIELD_W;
	localparam int CNT_W = $clog2(FIELD_W);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(FIELD_W - 1);

	logic [A_WIDTH-1:0] a_q;
	logic [PW-1:0]      prod_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [A_WIDTH:0]   sum;

	// Add the multiplicand into the upper half when the current bit is set.
	assign sum = {1'b0, prod_q[PW-1:FIELD_W]}
		+ (prod_q[0] ? {1'b0, a_q} : {(A_WIDTH + 1){1'b0}});

	// Step counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Product register: the multiplier bits shift out at the bottom as the
	// partial sum shifts in at the top.
	always_ff @(posedge clk) begin
		if (start) begin
			a_q    <= a;
			prod_q <= {{A_WIDTH{1'b0}}, b};
		end else if (busy_q) begin
			prod_q <= {sum, prod_q[FIELD_W-1:1]};
		end
	end

	assign busy    = busy_q;
	assign done    = done_q;
	assign product = prod_q;

endmodule

[rtl/bcu_serial_div.sv]
// ----------------------------------------------------------------------------
// Bit-serial divider
// Restoring divider that produces one quotient bit per cycle, most
// significant first, with the quotient shifting into the dividend register.
// ----------------------------------------------------------------------------
module bcu_serial_div #(
	parameter int DIVIDEND_WIDTH = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [DIVIDEND_WIDTH-1:0]   dividend,
	input  logic [bcu_pkg::FIELD_W-1:0] divisor,
	output logic                        busy,
	output logic                        done,
	output logic [DIVIDEND_WIDTH-1:0]   quotient
);
	import bcu_pkg::*;

	localparam int CNT_W = $clog2(DIVIDEND_WIDTH);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(DIVIDEND_WIDTH - 1);

	logic [DIVIDEND_WIDTH-1:0] dvd_q;
	logic [FIELD_W-1:0]        dsr_q;
	logic [FIELD_W-1:0]        rem_q;
	logic [CNT_W-1:0]          cnt_q;
	logic                      busy_q;
	logic                      done_q;
	logic [FIELD_W:0]          trial;
	logic [FIELD_W:0]          diff;
	logic                      qbit;

	// Bring down the next dividend bit and try to subtract the divisor.
	assign trial = {rem_q, dvd_q[DIVIDEND_WIDTH-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign qbit  = (trial >= {1'b0, dsr_q});

	// Step counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Partial remainder and dividend/quotient shift register.
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= qbit ? diff[FIELD_W-1:0] : trial[FIELD_W-1:0];
			dvd_q <= {dvd_q[DIVIDEND_WIDTH-2:0], qbit};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// Binomial coefficient unit testbench
// Drives pairs of set size and choose count into the unit over the input
// stream and checks every returned coefficient and overflow flag against a
// behavioral model of the multiplicative product. Both stream sides stall in
// random bursts, except in the tail of the run.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

	import bcu_pkg::*;

	localparam int      CLK_PERIOD   = 10;
	localparam int      RESULT_W     = RESULT_WIDTH_DEF;
	localparam int      RANDOM_OPS   = 240;
	localparam int      TAIL_ITEMS   = 40;
	// Longest item at the default width: 17 product steps before the product
	// saturates. The drain allows for 40 steps.
	localparam int      DRAIN_CYCLES = 40 * (RESULT_W + 67) + 20;
	localparam longint  CYCLE_LIMIT  = 5000000;

	// One input transaction.
	typedef struct packed {
		logic [FIELD_W-1:0] choose_count;
		logic [FIELD_W-1:0] set_size;
	} operand_t;

	// One output transaction.
	typedef struct packed {
		logic [FIELD_W-1:0] coefficient;
		logic               overflow;
	} binom_t;

	logic                   clk           = 1'b0;
	logic                   arst_n        = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	// choose_count[31:0], set_size[63:32]
	logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	// coefficient[31:0], overflow[32], zeros[39:33]
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	operand_t pending_ops[$];
	binom_t   binom_expected[$];
	int       src_gap        = 0;
	int       sink_gap       = 0;
	int       mismatch_count = 0;
	longint   cycle_count    = 0;

	binomial_coefficient_unit #(
		.RESULT_WIDTH(RESULT_W)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Expected coefficient: running product with the common factor of the
	// accumulator and the step index divided out first, so every step is exact.
	function automatic binom_t binom_predict(operand_t op);
		longint unsigned k, n, limit, acc, i, m, a, q, x, y, t;
		binom_t r;
		k = op.choose_count;
		n = op.set_size;
		limit = (RESULT_W >= 64) ? '1 : ((64'd1 << RESULT_W) - 1);
		acc = 1;
		r.overflow = 1'b0;
		r.coefficient = '0;
		if (k > n)
			return r;
		if (k > n / 2)
			k = n - k;
		for (i = 1; i <= k; i++) begin
			m = n - k + i;
			x = acc;
			y = i;
			while (y != 0) begin
				t = x % y;
				x = y;
				y = t;
			end
			a = acc / x;
			q = m / (i / x);
			// The partial products only grow, so the first step past the
			// limit settles the overflow.
			if (q != 0 && a > limit / q) begin
				r.overflow = 1'b1;
				break;
			end
			acc = a * q;
		end
		if (r.overflow)
			acc = limit;
		r.coefficient = acc[FIELD_W-1:0];
		return r;
	endfunction

	function automatic operand_t random_op();
		operand_t op;
		logic [FIELD_W-1:0] n, k;
		n = '0;
		k = '0;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				// Small sets, including choices just past the set size.
				n = $urandom_range(0, 70);
				k = $urandom_range(0, n + 2);
			end
			4: begin
				// Moderate sets with a narrow or nearly full choice.
				n = $urandom_range(0, 100000);
				k = $urandom_range(0, 4);
				if ($urandom_range(0, 1))
					k = n - k;
			end
			5: begin
				// Full-range set size with a narrow or nearly full choice.
				n = $urandom;
				k = $urandom_range(0, 3);
				if ($urandom_range(0, 1))
					k = n - k;
			end
			6: begin
				n = $urandom;
				k = $urandom;
			end
			7: begin
				// Choose count just above the set size.
				n = $urandom;
				k = n + $urandom_range(1, 8);
			end
			8: begin
				// Around the point where two-of-n stops fitting.
				n = $urandom_range(92600, 92760);
				k = 2;
			end
			default: begin
				// Mid-size sets with short products from either end.
				n = $urandom_range(30, 2000);
				k = $urandom_range(0, 12);
				if ($urandom_range(0, 1))
					k = n - k;
			end
		endcase
		op.choose_count = k;
		op.set_size     = n;
		return op;
	endfunction

	task automatic queue_op(input logic [FIELD_W-1:0] k, input logic [FIELD_W-1:0] n);
		operand_t op;
		op.choose_count = k;
		op.set_size     = n;
		pending_ops.push_back(op);
	endtask

	task automatic flag_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("ERROR: %s", msg);
	endtask

	// Stimulus, reset and end of run.
	initial begin
		// Directed operand pairs: empty set, choice past the set size, full
		// choice, range extremes, reflection of k, and saturation edges.
		queue_op(32'd0, 32'd0);
		queue_op(32'd1, 32'd0);
		queue_op(32'd0, 32'd1);
		queue_op(32'd1, 32'd1);
		queue_op(32'd0, 32'hFFFF_FFFF);
		queue_op(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_op(32'd1, 32'hFFFF_FFFF);
		queue_op(32'hFFFF_FFFE, 32'hFFFF_FFFF);
		queue_op(32'd2, 32'hFFFF_FFFF);
		queue_op(32'hFFFF_FFFF, 32'd0);
		queue_op(32'hFFFF_FFFF, 32'hFFFF_FFFE);
		queue_op(32'd5, 32'd10);
		queue_op(32'd6, 32'd10);
		queue_op(32'd17, 32'd34);
		queue_op(32'd16, 32'd33);
		queue_op(32'd17, 32'd35);
		queue_op(32'd34, 32'd68);
		queue_op(32'd2, 32'd92682);
		queue_op(32'd2, 32'd92683);
		queue_op(32'd3, 32'd2345);
		queue_op(32'h8000_0000, 32'hFFFF_FFFF);
		queue_op(32'h5555_5555, 32'hAAAA_AAAA);
		repeat (RANDOM_OPS)
			pending_ops.push_back(random_op());

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_ops.size() != 0 || binom_expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("binomial_coefficient_unit: match");
		else
			$display("binomial_coefficient_unit: mismatch");
		$finish;
	end

	// Input side: present the oldest pending pair and hold it until taken.
	always @(posedge clk or negedge arst_n) begin : drive_operands
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			src_gap = 0;
		end else begin
			// The unit took a transaction: record what it must return.
			if (s_axis_tvalid && s_axis_tready) begin
				binom_expected.push_back(binom_predict(pending_ops[0]));
				void'(pending_ops.pop_front());
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (src_gap > 0) begin
					src_gap--;
					s_axis_tvalid <= 1'b0;
				end else if (pending_ops.size() > 0) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= {pending_ops[0].set_size, pending_ops[0].choose_count};
					if (pending_ops.size() > TAIL_ITEMS && $urandom_range(0, 3) == 0)
						src_gap = $urandom_range(1, 5);
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Output side: random back-pressure and a check of every result.
	always @(posedge clk or negedge arst_n) begin : check_results
		binom_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			sink_gap = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (binom_expected.size() == 0) begin
					flag_mismatch($sformatf("unexpected result: coefficient %0h overflow %0b",
						m_axis_tdata[FIELD_W-1:0], m_axis_tdata[FIELD_W]));
				end else begin
					want = binom_expected.pop_front();
					if (m_axis_tdata[FIELD_W-1:0] !== want.coefficient ||
							m_axis_tdata[FIELD_W] !== want.overflow ||
							m_axis_tdata[OUT_TDATA_W-1:FIELD_W+1] !== '0)
						flag_mismatch($sformatf(
							"coefficient %0h/%0h overflow %0b/%0b pad %0h (expected/actual)",
							want.coefficient, m_axis_tdata[FIELD_W-1:0],
							want.overflow, m_axis_tdata[FIELD_W],
							m_axis_tdata[OUT_TDATA_W-1:FIELD_W+1]));
				end
			end
			if (sink_gap > 0) begin
				sink_gap--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				if (pending_ops.size() > TAIL_ITEMS && $urandom_range(0, 5) == 0)
					sink_gap = $urandom_range(1, 5);
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin : watchdog
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("binomial_coefficient_unit: mismatch");
			$finish;
		end
	end

endmodule
